### hw/rtl/uvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, register map, latencies and types of the UV-sphere vertex
// generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int IDX_W      = 10;
    localparam int GP_W       = 11;
    localparam int CTR_W      = 24;
    localparam int RAD_W      = 23;
    localparam int POS_W      = 24;
    localparam int NRM_W      = 18;
    localparam int VN_W       = 22;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int SC_LAT = 22;

    localparam logic [2:0] REG_GRID   = 3'd0;
    localparam logic [2:0] REG_CTR_X  = 3'd1;
    localparam logic [2:0] REG_CTR_Y  = 3'd2;
    localparam logic [2:0] REG_CTR_Z  = 3'd3;
    localparam logic [2:0] REG_RADIUS = 3'd4;

    localparam logic [GP_W-1:0]  GRID_RST   = 11'd24;
    localparam logic [RAD_W-1:0] RADIUS_RST = 23'd104858;

    typedef struct packed {
        logic            lu;
        logic            lv;
        logic [VN_W-1:0] vn;
        logic            last;
    } vtx_tag_t;

endpackage

### hw/rtl/uvs_angle_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_angle_div
// Pipelined restoring divider, one quotient bit per stage; keeps the low
// QUO_W quotient bits, which is the angle wrapped to one turn.
// ----------------------------------------------------------------------------
module uvs_angle_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 14,
    parameter int QUO_W = 16
) (
    input  logic             aclk,
    input  logic             adv,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [QUO_W-1:0] quo_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;

        if (s == 0) begin : g_first
            assign num_in = num;
            assign rem_in = '0;
            assign quo_in = '0;
        end else begin : g_next
            assign num_in = num_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign ge    = (trial >= {1'b0, den});
        assign diff  = ge ? (trial - {1'b0, den}) : trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                num_reg[s] <= num_in << 1;
                rem_reg[s] <= diff[DEN_W-1:0];
                quo_reg[s] <= {quo_in[QUO_W-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];

endmodule

### hw/rtl/uvs_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sincos
// Pipelined sine and cosine of an angle in turns: two lanes evaluate the
// nested Taylor series for the quadrant fraction and its complement.
// ----------------------------------------------------------------------------
module uvs_sincos
    import uvs_pkg::*;
#(
    parameter int ANG_W = 16
) (
    input  logic                    aclk,
    input  logic                    adv,
    input  logic [ANG_W-1:0]        ang,
    output logic signed [NRM_W-1:0] sin_o,
    output logic signed [NRM_W-1:0] cos_o
);

    localparam int LANE_D = SC_LAT - 1;
    localparam int ITERS  = 6;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [1:0]  QUAD_I   = 2'd0;
    localparam logic [1:0]  QUAD_II  = 2'd1;
    localparam logic [1:0]  QUAD_III = 2'd2;
    localparam logic [1:0]  QUAD_IV  = 2'd3;

    typedef struct packed {
        logic [30:0] z;
        logic [31:0] z2;
        logic [30:0] acc;
        logic [31:0] v;
        logic [29:0] q0;
    } lane_t;

    function automatic logic [7:0] term_div(input int it);
        logic [7:0] d;
        case (it)
            0:       d = 8'd156;
            1:       d = 8'd110;
            2:       d = 8'd72;
            3:       d = 8'd42;
            4:       d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    function automatic logic [29:0] term_recip(input int it);
        logic [29:0] m;
        case (it)
            0:       m = 30'd27531841;
            1:       m = 30'd39045157;
            2:       m = 30'd59652323;
            3:       m = 30'd102261126;
            4:       m = 30'd214748364;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

    function automatic lane_t st_z(input logic [30:0] u);
        lane_t       n;
        logic [61:0] p;
        n   = '0;
        p   = 62'(u) * 62'(HALF_PI_Q30);
        n.z = p[60:30];
        return n;
    endfunction

    function automatic lane_t st_z2(input lane_t c);
        lane_t       n;
        logic [61:0] p;
        n     = c;
        p     = 62'(c.z) * 62'(c.z);
        n.z2  = p[61:30];
        n.acc = ONE_Q30;
        return n;
    endfunction

    function automatic lane_t st_v(input lane_t c);
        lane_t       n;
        logic [62:0] p;
        n   = c;
        p   = 63'(c.z2) * 63'(c.acc);
        n.v = p[61:30];
        return n;
    endfunction

    function automatic lane_t st_q0(input lane_t c, input logic [29:0] m);
        lane_t       n;
        logic [61:0] p;
        n    = c;
        p    = 62'(c.v) * 62'(m);
        n.q0 = p[61:32];
        return n;
    endfunction

    function automatic lane_t st_acc(input lane_t c, input logic [7:0] d);
        lane_t       n;
        logic [37:0] qd;
        logic [37:0] r;
        logic [30:0] q;
        n     = c;
        qd    = 38'(c.q0) * 38'(d);
        r     = 38'(c.v) - qd;
        q     = 31'(c.q0) + 31'(r >= 38'(d));
        n.acc = ONE_Q30 - q;
        return n;
    endfunction

    function automatic lane_t st_s(input lane_t c);
        lane_t       n;
        logic [61:0] p;
        n   = c;
        p   = 62'(c.z) * 62'(c.acc);
        n.v = {1'b0, p[60:30]};
        return n;
    endfunction

    function automatic logic [16:0] to_q16(input logic [31:0] v);
        logic [32:0] t;
        logic [17:0] m;
        t = 33'(v) + 33'd8192;
        m = t[31:14];
        if (m > 18'd65536) begin
            m = 18'd65536;
        end
        return m[16:0];
    endfunction

    lane_t                   lane_reg [LANE_D][2];
    logic [1:0]              quad_reg [LANE_D];
    logic signed [NRM_W-1:0] sin_reg;
    logic signed [NRM_W-1:0] cos_reg;
    logic [29:0]             x30;
    logic [30:0]             u_in [2];

    assign x30     = 30'({ang[ANG_W-3:0]}) << (32 - ANG_W);
    assign u_in[0] = {1'b0, x30};
    assign u_in[1] = ONE_Q30 - {1'b0, x30};

    for (genvar l = 0; l < 2; l++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (adv) begin
                lane_reg[0][l] <= st_z(u_in[l]);
                lane_reg[1][l] <= st_z2(lane_reg[0][l]);
                lane_reg[LANE_D-1][l] <= st_s(lane_reg[LANE_D-2][l]);
            end
        end

        for (genvar it = 0; it < ITERS; it++) begin : g_iter
            localparam int SA = 2 + 3 * it;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    lane_reg[SA][l]   <= st_v(lane_reg[SA-1][l]);
                    lane_reg[SA+1][l] <= st_q0(lane_reg[SA][l], term_recip(it));
                    lane_reg[SA+2][l] <= st_acc(lane_reg[SA+1][l], term_div(it));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            quad_reg[0] <= ang[ANG_W-1:ANG_W-2];
            for (int s = 1; s < LANE_D; s++) begin
                quad_reg[s] <= quad_reg[s-1];
            end
        end
    end

    logic signed [NRM_W-1:0] mag_p;
    logic signed [NRM_W-1:0] mag_r;
    logic signed [NRM_W-1:0] sin_next;
    logic signed [NRM_W-1:0] cos_next;

    assign mag_p = $signed({1'b0, to_q16(lane_reg[LANE_D-1][0].v)});
    assign mag_r = $signed({1'b0, to_q16(lane_reg[LANE_D-1][1].v)});

    always_comb begin
        unique case (quad_reg[LANE_D-1])
            QUAD_I: begin
                sin_next = mag_p;
                cos_next = mag_r;
            end
            QUAD_II: begin
                sin_next = mag_r;
                cos_next = -mag_p;
            end
            QUAD_III: begin
                sin_next = -mag_p;
                cos_next = -mag_r;
            end
            QUAD_IV: begin
                sin_next = -mag_r;
                cos_next = mag_p;
            end
            default: begin
                sin_next = mag_p;
                cos_next = mag_r;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

### hw/rtl/uv_sphere_vertex_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// Expands one grid cell into its four corner vertices: normal, position,
// equal-area disk texture coordinate, local u/v and running vertex number.
//
//   port group   direction  transfer
//   s_*          in         one cell (colat_index, longit_index)
//   m_*          out        one vertex, four per cell
//   APB          in/out     register writes and reads, pready tied high
//
// One vertex per cycle leaves the pipeline unless m_ready is low, so a new cell
// is taken as the last corner of the previous cell issues; the corner sequencer
// in front of the pipeline sets that pace. Cell transfer to first vertex passes
// the issue registers, angle dividers, sine series stages and product registers.
// aresetn clears valid bits and the sequencer and sets the configuration
// registers to defaults. With m_ready low and a vertex waiting, all stages hold.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_unit
    import uvs_pkg::*;
#(
    parameter int MAX_PRECISION   = 1024,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [IDX_W-1:0]        s_colat_index,
    input  logic [IDX_W-1:0]        s_longit_index,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_pos_x,
    output logic signed [POS_W-1:0] m_pos_y,
    output logic signed [POS_W-1:0] m_pos_z,
    output logic signed [NRM_W-1:0] m_normal_x,
    output logic signed [NRM_W-1:0] m_normal_y,
    output logic signed [NRM_W-1:0] m_normal_z,
    output logic signed [NRM_W-1:0] m_disk_u,
    output logic signed [NRM_W-1:0] m_disk_v,
    output logic                    m_local_u,
    output logic                    m_local_v,
    output logic [VN_W-1:0]         m_vertex_number,
    output logic                    m_last_corner,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int P_W   = $clog2(MAX_PRECISION + 1);
    localparam int K_W   = IDX_W + 1;
    localparam int NUM_W = K_W + ANGLE_FRAC_BITS + 1;
    localparam int DEN_W = P_W + 2;
    localparam int LAT   = NUM_W + SC_LAT + 5;

    // configuration registers
    logic [GP_W-1:0]         grid_reg;
    logic signed [CTR_W-1:0] ctr_x_reg;
    logic signed [CTR_W-1:0] ctr_y_reg;
    logic signed [CTR_W-1:0] ctr_z_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic                    cfg_wr;
    logic [2:0]              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg   <= GRID_RST;
            ctr_x_reg  <= '0;
            ctr_y_reg  <= '0;
            ctr_z_reg  <= '0;
            radius_reg <= RADIUS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GRID:   grid_reg   <= pwdata[GP_W-1:0];
                REG_CTR_X:  ctr_x_reg  <= pwdata[CTR_W-1:0];
                REG_CTR_Y:  ctr_y_reg  <= pwdata[CTR_W-1:0];
                REG_CTR_Z:  ctr_z_reg  <= pwdata[CTR_W-1:0];
                REG_RADIUS: radius_reg <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GRID:   prdata = APB_DATA_W'(grid_reg);
            REG_CTR_X:  prdata = APB_DATA_W'(ctr_x_reg);
            REG_CTR_Y:  prdata = APB_DATA_W'(ctr_y_reg);
            REG_CTR_Z:  prdata = APB_DATA_W'(ctr_z_reg);
            REG_RADIUS: prdata = APB_DATA_W'(radius_reg);
            default:    prdata = '0;
        endcase
    end

    logic [P_W-1:0] prec;

    always_comb begin
        if (grid_reg == '0) begin
            prec = P_W'(1);
        end else if (32'(grid_reg) > MAX_PRECISION) begin
            prec = P_W'(MAX_PRECISION);
        end else begin
            prec = P_W'(grid_reg);
        end
    end

    // pipeline control
    logic adv;
    logic s_fire;
    logic busy_reg;
    logic [1:0] cnt_reg;
    logic vld_reg [LAT];

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv && (!busy_reg || cnt_reg == 2'd3);
    assign s_fire  = s_valid && s_ready;

    logic [IDX_W-1:0] cell_i_reg;
    logic [IDX_W-1:0] cell_j_reg;
    logic             iss_vld_reg;
    logic [K_W-1:0]   iss_k_reg;
    logic [K_W-1:0]   iss_m_reg;
    vtx_tag_t         iss_tag_reg;
    vtx_tag_t         iss_tag_next;
    logic [31:0]      cell_num;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            iss_vld_reg <= 1'b0;
        end else begin
            if (adv) begin
                iss_vld_reg <= busy_reg;
            end
            if (s_fire) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (adv && busy_reg) begin
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + 2'd1;
                end
            end
        end
    end

    assign cell_num = 32'(cell_j_reg) * 32'(prec) + 32'(cell_i_reg);

    always_comb begin
        iss_tag_next.lu   = cnt_reg[0];
        iss_tag_next.lv   = cnt_reg[1];
        iss_tag_next.vn   = {cell_num[VN_W-3:0], cnt_reg};
        iss_tag_next.last = (cnt_reg == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cell_i_reg <= s_colat_index;
            cell_j_reg <= s_longit_index;
        end
        if (adv) begin
            iss_k_reg   <= K_W'(cell_i_reg) + K_W'(cnt_reg[1]);
            iss_m_reg   <= K_W'(cell_j_reg) + K_W'(cnt_reg[0]);
            iss_tag_reg <= iss_tag_next;
        end
    end

    // valid and tag travel alongside the data
    vtx_tag_t tag_reg [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < LAT; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= iss_vld_reg;
            for (int s = 1; s < LAT; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= iss_tag_reg;
            for (int s = 1; s < LAT; s++) begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    // angle division
    logic [NUM_W-1:0] num_t;
    logic [NUM_W-1:0] num_l;
    logic [NUM_W-1:0] num_h;
    logic [DEN_W-1:0] den_2p;
    logic [DEN_W-1:0] den_4p;
    logic [ANGLE_FRAC_BITS-1:0] ang_t;
    logic [ANGLE_FRAC_BITS-1:0] ang_l;
    logic [ANGLE_FRAC_BITS-1:0] ang_h;

    assign num_t  = (NUM_W'(iss_k_reg) << ANGLE_FRAC_BITS) + NUM_W'(prec);
    assign num_l  = (NUM_W'(iss_m_reg) << (ANGLE_FRAC_BITS + 1)) + NUM_W'(prec);
    assign num_h  = (NUM_W'(iss_k_reg) << ANGLE_FRAC_BITS) + (NUM_W'(prec) << 1);
    assign den_2p = DEN_W'(prec) << 1;
    assign den_4p = DEN_W'(prec) << 2;

    uvs_angle_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(ANGLE_FRAC_BITS)) u_div_t (
        .aclk (aclk), .adv (adv), .num (num_t), .den (den_2p), .quo (ang_t)
    );
    uvs_angle_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(ANGLE_FRAC_BITS)) u_div_l (
        .aclk (aclk), .adv (adv), .num (num_l), .den (den_2p), .quo (ang_l)
    );
    uvs_angle_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(ANGLE_FRAC_BITS)) u_div_h (
        .aclk (aclk), .adv (adv), .num (num_h), .den (den_4p), .quo (ang_h)
    );

    // sine and cosine
    logic signed [NRM_W-1:0] st;
    logic signed [NRM_W-1:0] ct;
    logic signed [NRM_W-1:0] sl;
    logic signed [NRM_W-1:0] cl;
    logic signed [NRM_W-1:0] sh;
    logic signed [NRM_W-1:0] ch;

    uvs_sincos #(.ANG_W(ANGLE_FRAC_BITS)) u_sc_t (
        .aclk (aclk), .adv (adv), .ang (ang_t), .sin_o (st), .cos_o (ct)
    );
    uvs_sincos #(.ANG_W(ANGLE_FRAC_BITS)) u_sc_l (
        .aclk (aclk), .adv (adv), .ang (ang_l), .sin_o (sl), .cos_o (cl)
    );
    uvs_sincos #(.ANG_W(ANGLE_FRAC_BITS)) u_sc_h (
        .aclk (aclk), .adv (adv), .ang (ang_h), .sin_o (sh), .cos_o (ch)
    );

    // products of Q16 values
    logic signed [2*NRM_W-1:0] pr_nx_reg;
    logic signed [2*NRM_W-1:0] pr_nz_reg;
    logic signed [2*NRM_W-1:0] pr_du_reg;
    logic signed [2*NRM_W-1:0] pr_dv_reg;
    logic signed [NRM_W-1:0]   ny_p1_reg;
    logic signed [NRM_W-1:0]   nx_p2_reg, ny_p2_reg, nz_p2_reg, du_p2_reg, dv_p2_reg;
    logic signed [NRM_W-1:0]   nx_p3_reg, ny_p3_reg, nz_p3_reg, du_p3_reg, dv_p3_reg;
    logic signed [NRM_W-1:0]   nx_p4_reg, ny_p4_reg, nz_p4_reg, du_p4_reg, dv_p4_reg;
    logic signed [NRM_W-1:0]   nx_out_reg, ny_out_reg, nz_out_reg, du_out_reg, dv_out_reg;
    logic signed [RAD_W+NRM_W:0] px_reg, py_reg, pz_reg;
    logic signed [POS_W+1:0]   rx_reg, ry_reg, rz_reg;
    logic signed [POS_W-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [2*NRM_W-1:0] neg_dv;
    logic signed [RAD_W:0]     rad_s;

    assign neg_dv = -pr_dv_reg;
    assign rad_s  = $signed({1'b0, radius_reg});

    function automatic logic signed [NRM_W-1:0] rnd16(input logic signed [2*NRM_W-1:0] v);
        logic signed [2*NRM_W-1:0] t;
        t = (v + (2*NRM_W)'(32768)) >>> 16;
        return t[NRM_W-1:0];
    endfunction

    function automatic logic signed [POS_W+1:0] rnd_pos(
        input logic signed [RAD_W+NRM_W:0] v
    );
        logic signed [RAD_W+NRM_W:0] t;
        t = (v + (RAD_W+NRM_W+1)'(32768)) >>> 16;
        return t[POS_W+1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(
        input logic signed [POS_W+1:0] r,
        input logic signed [CTR_W-1:0] c
    );
        logic signed [POS_W+2:0] s;
        s = (POS_W+3)'(r) + (POS_W+3)'(c);
        if (s > (POS_W+3)'(8388607)) begin
            s = (POS_W+3)'(8388607);
        end else if (s < -(POS_W+3)'(8388608)) begin
            s = -(POS_W+3)'(8388608);
        end
        return s[POS_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_nx_reg <= st * cl;
            pr_nz_reg <= st * sl;
            pr_du_reg <= sh * sl;
            pr_dv_reg <= sh * cl;
            ny_p1_reg <= ct;

            nx_p2_reg <= rnd16(pr_nx_reg);
            ny_p2_reg <= ny_p1_reg;
            nz_p2_reg <= rnd16(pr_nz_reg);
            du_p2_reg <= rnd16(pr_du_reg);
            dv_p2_reg <= rnd16(neg_dv);

            px_reg    <= rad_s * nx_p2_reg;
            py_reg    <= rad_s * ny_p2_reg;
            pz_reg    <= rad_s * nz_p2_reg;
            nx_p3_reg <= nx_p2_reg;
            ny_p3_reg <= ny_p2_reg;
            nz_p3_reg <= nz_p2_reg;
            du_p3_reg <= du_p2_reg;
            dv_p3_reg <= dv_p2_reg;

            rx_reg    <= rnd_pos(px_reg);
            ry_reg    <= rnd_pos(py_reg);
            rz_reg    <= rnd_pos(pz_reg);
            nx_p4_reg <= nx_p3_reg;
            ny_p4_reg <= ny_p3_reg;
            nz_p4_reg <= nz_p3_reg;
            du_p4_reg <= du_p3_reg;
            dv_p4_reg <= dv_p3_reg;

            pos_x_reg  <= sat_pos(rx_reg, ctr_x_reg);
            pos_y_reg  <= sat_pos(ry_reg, ctr_y_reg);
            pos_z_reg  <= sat_pos(rz_reg, ctr_z_reg);
            nx_out_reg <= nx_p4_reg;
            ny_out_reg <= ny_p4_reg;
            nz_out_reg <= nz_p4_reg;
            du_out_reg <= du_p4_reg;
            dv_out_reg <= dv_p4_reg;
        end
    end

    assign m_valid         = vld_reg[LAT-1];
    assign m_pos_x         = pos_x_reg;
    assign m_pos_y         = pos_y_reg;
    assign m_pos_z         = pos_z_reg;
    assign m_normal_x      = nx_out_reg;
    assign m_normal_y      = ny_out_reg;
    assign m_normal_z      = nz_out_reg;
    assign m_disk_u        = du_out_reg;
    assign m_disk_v        = dv_out_reg;
    assign m_local_u       = tag_reg[LAT-1].lu;
    assign m_local_v       = tag_reg[LAT-1].lv;
    assign m_vertex_number = tag_reg[LAT-1].vn;
    assign m_last_corner   = tag_reg[LAT-1].last;

endmodule
